// ===== rtl/core/spm_pkg.sv =====
// spm_pkg: shared types and constants for the shortest-path vertex membership block
// no dependencies; imported by every module under rtl/core
package spm_pkg;

  // distance arithmetic: unreached marker fits in 20 bits, sums need one more
  localparam int DIST_W    = 20;
  localparam int SUM_W     = 21;
  localparam int COST_IN_W = 16;
  localparam logic [DIST_W-1:0] UNREACHED = 20'd1000000;

  // stream word layout
  localparam int VTX_IN_W  = 6;
  localparam int A_LSB     = 0;
  localparam int B_LSB     = 6;
  localparam int P_LSB     = 12;
  localparam int COST_LSB  = 18;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDIRECTED  = 1'b1;

  // item kinds
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_E_RD,
    ST_E_CHK,
    ST_E_MIR,
    ST_Q_PS,
    ST_Q_PE,
    ST_Q_PP,
    ST_Q_PCHK,
    ST_Q_INIT,
    ST_Q_SEL,
    ST_Q_RELAX,
    ST_Q_DRD,
    ST_Q_DCHK,
    ST_Q_TRACE,
    ST_Q_TWAIT,
    ST_DONE
  } state_t;

  // operands of the shared add/compare unit: result is (a + b) < c
  typedef struct packed {
    logic [DIST_W-1:0]    a;
    logic [COST_IN_W-1:0] b;
    logic [DIST_W-1:0]    c;
  } cmp_op_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             lt;
  } cmp_res_t;

  // write enables of the per-query work memories
  typedef struct packed {
    logic distance;
    logic parent;
    logic settled;
  } work_we_t;

endpackage

// ===== rtl/core/spm_cmp.sv =====
// spm_cmp: shared add and compare unit used for minimum search, relaxation and reach check
// depends on spm_pkg
module spm_cmp
  import spm_pkg::*;
(
  input  cmp_op_t  op,
  output cmp_res_t res
);

  logic [SUM_W-1:0] sum;

  // one wide add followed by one compare
  assign sum     = SUM_W'(op.a) + SUM_W'(op.b);
  assign res.sum = sum;
  assign res.lt  = (sum < SUM_W'(op.c));

endmodule

// ===== rtl/core/spm_graph.sv =====
// spm_graph: edge memory (valid bit and cost) and vertex presence memory
// depends on spm_pkg; cleared by the sequencer in a sweep after reset
module spm_graph
  import spm_pkg::*;
#(
  parameter int VW = 6,
  parameter int CW = 16
) (
  input  logic            clk,
  input  logic            edge_we,
  input  logic [2*VW-1:0] edge_waddr,
  input  logic [CW:0]     edge_wdata,
  input  logic [2*VW-1:0] edge_raddr,
  output logic [CW:0]     edge_rdata,
  input  logic            pres_we,
  input  logic [VW-1:0]   pres_waddr,
  input  logic            pres_wdata,
  input  logic [VW-1:0]   pres_raddr,
  output logic            pres_rdata
);

  // word is {valid, cost}, addressed by {source, destination}
  logic [CW:0] edge_mem [(1 << (2*VW))];
  logic        pres_mem [(1 << VW)];

  // edge memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

  // presence memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_waddr] <= pres_wdata;
    end
    pres_rdata <= pres_mem[pres_raddr];
  end

endmodule

// ===== rtl/core/spm_work.sv =====
// spm_work: per-query distance, parent and settled memories
// depends on spm_pkg; rebuilt by the sequencer at the start of every query
module spm_work
  import spm_pkg::*;
#(
  parameter int VW = 6
) (
  input  logic              clk,
  input  work_we_t          we,
  input  logic [VW-1:0]     waddr,
  input  logic [DIST_W-1:0] wdist,
  input  logic [VW-1:0]     wparent,
  input  logic              wsettled,
  input  logic [VW-1:0]     raddr,
  output logic [DIST_W-1:0] rdist,
  output logic [VW-1:0]     rparent,
  output logic              rsettled
);

  logic [DIST_W-1:0] dist_mem    [(1 << VW)];
  logic [VW-1:0]     parent_mem  [(1 << VW)];
  logic              settled_mem [(1 << VW)];

  // shared write address, separate enables, one registered read address
  always_ff @(posedge clk) begin
    if (we.distance) begin
      dist_mem[waddr] <= wdist;
    end
    if (we.parent) begin
      parent_mem[waddr] <= wparent;
    end
    if (we.settled) begin
      settled_mem[waddr] <= wsettled;
    end
    rdist    <= dist_mem[raddr];
    rparent  <= parent_mem[raddr];
    rsettled <= settled_mem[raddr];
  end

endmodule

// ===== rtl/core/shortest_path_vertex_membership.sv =====
// shortest_path_vertex_membership: edge store and array Dijkstra with path membership answer
// depends on spm_pkg, spm_cmp, spm_graph, spm_work
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tuser kind; tdata a, b, probe, cost
//   m_*       out  m_tvalid/m_tready  tdata on_path, status
//   cfg_*     in   cfg_wen            cfg_index, cfg_wdata (no wait)
//
// after reset a clearing pass sweeps the edge memory and the vertex presence memory; s_tready
// stays low meanwhile, config writes are taken. edge word: a read, a duplicate check and an
// optional mirror write. query word: an init scan of the work memories, one minimum scan
// and one relax scan per reached vertex through the single read port of the work memories,
// one closing scan, then a trace back along the parents, one path step at a time.
// one word is in work at a time; the result register lets the next word in while a
// finished result waits on m_tready.
module shortest_path_vertex_membership
  import spm_pkg::*;
#(
  parameter int NUM_VERTICES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // vertex_a[5:0], vertex_b[11:6], probe_vertex[17:12],
                                           // edge_cost[33:18], zero pad
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // on_path[0], status[1], zero pad
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW    = $clog2(NUM_VERTICES);
  localparam int CW    = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W;
  localparam int AW    = 2 * VW;
  localparam int CNT_W = AW + 1;
  localparam logic [CNT_W-1:0] NV_CNT  = CNT_W'(NUM_VERTICES);
  localparam logic [CNT_W-1:0] NV_LAST = CNT_W'(NUM_VERTICES - 1);
  localparam logic [CNT_W-1:0] CLR_END = {1'b1, {AW{1'b0}}};

  state_t state, state_next;

  // control registers
  logic [CNT_W-1:0] cnt;
  logic             pv;
  logic             found;
  logic             use_weights;
  logic             undirected;
  logic             res_on_path;
  logic             res_status;
  logic             pres_ok;

  // payload registers
  logic [VW-1:0]     va, vb, vp;
  logic [CW-1:0]     cost;
  logic [VW-1:0]     pidx;
  logic [VW-1:0]     best_u;
  logic [DIST_W-1:0] best_dist;
  logic [VW-1:0]     cur;

  // memory ports
  logic            g_edge_we;
  logic [AW-1:0]   g_edge_waddr;
  logic [CW:0]     g_edge_wdata;
  logic [AW-1:0]   g_edge_raddr;
  logic [CW:0]     g_edge_rdata;
  logic            g_pres_we;
  logic [VW-1:0]   g_pres_waddr;
  logic            g_pres_wdata;
  logic [VW-1:0]   g_pres_raddr;
  logic            g_pres_rdata;

  work_we_t          w_we;
  logic [VW-1:0]     w_waddr;
  logic [DIST_W-1:0] w_wdist;
  logic [VW-1:0]     w_wparent;
  logic              w_wsettled;
  logic [VW-1:0]     w_raddr;
  logic [DIST_W-1:0] w_rdist;
  logic [VW-1:0]     w_rparent;
  logic              w_rsettled;

  cmp_op_t  cmp_op;
  cmp_res_t cmp_res;

  // decode helpers
  logic          s_acc;
  logic          in_kind;
  logic          a_ok, b_ok, p_ok;
  logic          in_range;
  logic [VW-1:0] cnt_idx;
  logic          scan_end;
  logic          sel_take;
  logic          fin_found;
  logic [VW-1:0] fin_u;
  logic          rel_take;
  logic          dup;
  logic          out_load;

  spm_cmp u_cmp (
    .op  (cmp_op),
    .res (cmp_res)
  );

  spm_graph #(.VW(VW), .CW(CW)) u_graph (
    .clk        (clk),
    .edge_we    (g_edge_we),
    .edge_waddr (g_edge_waddr),
    .edge_wdata (g_edge_wdata),
    .edge_raddr (g_edge_raddr),
    .edge_rdata (g_edge_rdata),
    .pres_we    (g_pres_we),
    .pres_waddr (g_pres_waddr),
    .pres_wdata (g_pres_wdata),
    .pres_raddr (g_pres_raddr),
    .pres_rdata (g_pres_rdata)
  );

  spm_work #(.VW(VW)) u_work (
    .clk      (clk),
    .we       (w_we),
    .waddr    (w_waddr),
    .wdist    (w_wdist),
    .wparent  (w_wparent),
    .wsettled (w_wsettled),
    .raddr    (w_raddr),
    .rdist    (w_rdist),
    .rparent  (w_rparent),
    .rsettled (w_rsettled)
  );

  // input handshake and range checks
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign in_kind  = s_tuser;
  assign a_ok     = (32'(s_tdata[A_LSB +: VTX_IN_W]) < 32'(NUM_VERTICES));
  assign b_ok     = (32'(s_tdata[B_LSB +: VTX_IN_W]) < 32'(NUM_VERTICES));
  assign p_ok     = (32'(s_tdata[P_LSB +: VTX_IN_W]) < 32'(NUM_VERTICES));
  assign in_range = a_ok && b_ok && ((in_kind == KIND_EDGE) || p_ok);

  // scan bookkeeping
  assign cnt_idx   = cnt[VW-1:0];
  assign scan_end  = (cnt == NV_CNT);
  assign sel_take  = pv && !w_rsettled && cmp_res.lt;
  assign fin_found = found || sel_take;
  assign fin_u     = sel_take ? pidx : best_u;
  assign rel_take  = pv && g_edge_rdata[CW] && cmp_res.lt;
  assign dup       = g_edge_rdata[CW];
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CLR_END) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_acc) begin
          if (!in_range) state_next = ST_DONE;
          else if (in_kind == KIND_QUERY) state_next = ST_Q_PS;
          else state_next = ST_E_RD;
        end
      end
      ST_E_RD:  state_next = ST_E_CHK;
      ST_E_CHK: begin
        if (!dup && undirected) state_next = ST_E_MIR;
        else state_next = ST_DONE;
      end
      ST_E_MIR:  state_next = ST_DONE;
      ST_Q_PS:   state_next = ST_Q_PE;
      ST_Q_PE:   state_next = ST_Q_PP;
      ST_Q_PP:   state_next = ST_Q_PCHK;
      ST_Q_PCHK: begin
        if (pres_ok && g_pres_rdata) state_next = ST_Q_INIT;
        else state_next = ST_DONE;
      end
      ST_Q_INIT: begin
        if (cnt == NV_LAST) state_next = ST_Q_SEL;
      end
      ST_Q_SEL: begin
        if (scan_end) state_next = fin_found ? ST_Q_RELAX : ST_Q_DRD;
      end
      ST_Q_RELAX: begin
        if (scan_end) state_next = ST_Q_SEL;
      end
      ST_Q_DRD:  state_next = ST_Q_DCHK;
      ST_Q_DCHK: state_next = cmp_res.lt ? ST_Q_TRACE : ST_DONE;
      ST_Q_TRACE: begin
        if (cnt == NV_CNT || cur == vp || cur == va) state_next = ST_DONE;
        else state_next = ST_Q_TWAIT;
      end
      ST_Q_TWAIT: state_next = ST_Q_TRACE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and shared unit controls
  always_comb begin
    g_edge_we    = 1'b0;
    g_edge_waddr = {va, vb};
    g_edge_wdata = {1'b1, cost};
    g_edge_raddr = {va, vb};
    g_pres_we    = 1'b0;
    g_pres_waddr = va;
    g_pres_wdata = 1'b1;
    g_pres_raddr = va;
    w_we         = '0;
    w_waddr      = cnt_idx;
    w_wdist      = UNREACHED;
    w_wparent    = cnt_idx;
    w_wsettled   = 1'b0;
    w_raddr      = cnt_idx;
    cmp_op       = '0;
    case (state)
      ST_CLEAR: begin
        g_edge_we    = 1'b1;
        g_edge_waddr = cnt[AW-1:0];
        g_edge_wdata = '0;
        g_pres_we    = 1'b1;
        g_pres_waddr = cnt_idx;
        g_pres_wdata = 1'b0;
      end
      ST_E_RD: begin
        g_pres_we = 1'b1;
      end
      ST_E_CHK: begin
        g_pres_we    = 1'b1;
        g_pres_waddr = vb;
        g_edge_we    = !dup;
      end
      ST_E_MIR: begin
        g_edge_we    = 1'b1;
        g_edge_waddr = {vb, va};
      end
      ST_Q_PE: g_pres_raddr = vb;
      ST_Q_PP: g_pres_raddr = vp;
      ST_Q_INIT: begin
        w_we    = '{distance: 1'b1, parent: 1'b1, settled: 1'b1};
        w_wdist = (cnt_idx == va) ? '0 : UNREACHED;
      end
      ST_Q_SEL: begin
        // minimum search: dist < best, best starts at the unreached marker
        cmp_op.a = w_rdist;
        cmp_op.c = best_dist;
        if (scan_end && fin_found) begin
          w_we.settled = 1'b1;
          w_waddr      = fin_u;
          w_wsettled   = 1'b1;
        end
      end
      ST_Q_RELAX: begin
        // relaxation: dist[u] + cost < dist[nb], cost is 1 when weights are off
        g_edge_raddr = {best_u, cnt_idx};
        cmp_op.a     = best_dist;
        cmp_op.b     = use_weights ? COST_IN_W'(g_edge_rdata[CW-1:0]) : COST_IN_W'(1);
        cmp_op.c     = w_rdist;
        w_waddr      = pidx;
        w_wdist      = cmp_res.sum[DIST_W-1:0];
        w_wparent    = best_u;
        if (rel_take) begin
          w_we.distance = 1'b1;
          w_we.parent   = 1'b1;
        end
      end
      ST_Q_DRD: w_raddr = vb;
      ST_Q_DCHK: begin
        cmp_op.a = w_rdist;
        cmp_op.c = UNREACHED;
      end
      ST_Q_TRACE: w_raddr = cur;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      pv          <= 1'b0;
      found       <= 1'b0;
      use_weights <= 1'b1;
      undirected  <= 1'b1;
      m_tvalid    <= 1'b0;
      res_on_path <= 1'b0;
      res_status  <= 1'b0;
      pres_ok     <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= ((state == ST_Q_SEL) || (state == ST_Q_RELAX)) && !scan_end;

      // configuration writes
      if (cfg_wen) begin
        case (cfg_index)
          REG_USE_WEIGHTS: use_weights <= cfg_wdata[0];
          REG_UNDIRECTED:  undirected  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      // shared counter: clear sweep, scans and path steps
      case (state)
        ST_CLEAR:   cnt <= cnt + CNT_W'(1);
        ST_IDLE:    cnt <= '0;
        ST_Q_INIT:  cnt <= (cnt == NV_LAST) ? '0 : cnt + CNT_W'(1);
        ST_Q_SEL,
        ST_Q_RELAX: cnt <= scan_end ? '0 : cnt + CNT_W'(1);
        ST_Q_DCHK:  cnt <= '0;
        ST_Q_TWAIT: cnt <= cnt + CNT_W'(1);
        default: begin
        end
      endcase

      // minimum search state
      if (state == ST_Q_SEL && sel_take) begin
        found <= 1'b1;
      end else if (state == ST_Q_INIT || (state == ST_Q_RELAX && scan_end)) begin
        found <= 1'b0;
      end

      // presence accumulation
      case (state)
        ST_Q_PE: pres_ok <= g_pres_rdata;
        ST_Q_PP: pres_ok <= pres_ok && g_pres_rdata;
        default: begin
        end
      endcase

      // result flags
      if (s_acc) begin
        res_on_path <= 1'b0;
        res_status  <= 1'b0;
      end else if (state == ST_E_CHK) begin
        res_status <= dup;
      end else if (state == ST_Q_TRACE && cnt != NV_CNT && cur == vp) begin
        res_on_path <= 1'b1;
      end

      // result register
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      va   <= VW'(s_tdata[A_LSB +: VTX_IN_W]);
      vb   <= VW'(s_tdata[B_LSB +: VTX_IN_W]);
      vp   <= VW'(s_tdata[P_LSB +: VTX_IN_W]);
      cost <= s_tdata[COST_LSB +: CW];
    end
    pidx <= cnt_idx;
    if (state == ST_Q_SEL && sel_take) begin
      best_u    <= pidx;
      best_dist <= w_rdist;
    end else if (state == ST_Q_INIT || (state == ST_Q_RELAX && scan_end)) begin
      best_dist <= UNREACHED;
    end
    if (state == ST_Q_DCHK) begin
      cur <= vb;
    end else if (state == ST_Q_TWAIT) begin
      cur <= w_rparent;
    end
    if (out_load) begin
      m_tdata <= {{(M_TDATA_W-2){1'b0}}, res_status, res_on_path};
    end
  end

endmodule

// ===== rtl/core/spm_chk.sv =====
// spm_chk: port-level checks for shortest_path_vertex_membership, bound to the top level
// depends on spm_pkg
module spm_chk
  import spm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // clearing pass follows reset, so no word is taken right after it
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // one word in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after an accepted word");

  // a result never carries both the query answer and the duplicate flag
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("on_path and status both set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed or dropped while stalled");

endmodule

bind shortest_path_vertex_membership spm_chk u_spm_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
